>>> rtl/core/q2e_pkg.sv
`timescale 1ns / 1ps
package q2e_pkg;
    localparam int TAB_LEN = 24;
    localparam int AW = 43;        // CORDIC datapath width
    localparam int ACC_W = 28;     // angle accumulator width
    localparam logic signed [ACC_W-1:0] HALF_TURN = 28'sd11796480;
    localparam logic [15:0] RIGHT_ANGLE_Q96 = 16'd5760;
    localparam logic [15:0] FULL_TURN_Q96 = 16'd23040;
    localparam logic [1:0] POLE_NONE = 2'd0;
    localparam logic [1:0] POLE_NORTH = 2'd1;
    localparam logic [1:0] POLE_SOUTH = 2'd2;

    typedef struct packed {
        logic signed [AW-1:0]    xv;
        logic signed [AW-1:0]    yv;
        logic signed [ACC_W-1:0] acc;
    } cordic_t;

    function automatic logic signed [ACC_W-1:0] atan_entry(input int i);
        logic signed [ACC_W-1:0] r;
        case (i)
            0: r = 28'sd2949120;
            1: r = 28'sd1740967;
            2: r = 28'sd919879;
            3: r = 28'sd466945;
            4: r = 28'sd234379;
            5: r = 28'sd117304;
            6: r = 28'sd58666;
            7: r = 28'sd29335;
            8: r = 28'sd14668;
            9: r = 28'sd7334;
            10: r = 28'sd3667;
            11: r = 28'sd1833;
            12: r = 28'sd917;
            13: r = 28'sd458;
            14: r = 28'sd229;
            15: r = 28'sd115;
            16: r = 28'sd57;
            17: r = 28'sd29;
            18: r = 28'sd14;
            19: r = 28'sd7;
            20: r = 28'sd4;
            21: r = 28'sd2;
            22: r = 28'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction
endpackage

>>> rtl/core/quaternion_to_euler_angles.sv
`timescale 1ns / 1ps
// Channel   | Signals                                   | Transaction
// ----------+-------------------------------------------+---------------------------
// input     | start, busy, quat_x/y/z/w                 | start high, busy low
// config    | cfg_valid, cfg_ready, cfg_data            | valid and ready high
// result    | done, angle_x/y/z_deg, pole_case          | done high for one cycle
//
// One quaternion enters per cycle; busy is always low. From the accepting
// edge to done the data passes three operand stages, the radicand product,
// 32 square-root cells, the atan2 fold stage, CORDIC_STAGES rotation cells
// (capped at TAB_LEN) and the output register.
// rst_n clears only the valid shift line and sets the threshold register to 32735.
// The receiver cannot stall: done strobes once per result.
module quaternion_to_euler_angles #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    input  logic signed [15:0] quat_w,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [15:0]        cfg_data,
    output logic               done,
    output logic signed [15:0] angle_x_deg,
    output logic signed [15:0] angle_y_deg,
    output logic signed [15:0] angle_z_deg,
    output logic [1:0]         pole_case
);
    localparam int AW = q2e_pkg::AW;
    localparam int NS = (CORDIC_STAGES < q2e_pkg::TAB_LEN) ? CORDIC_STAGES
                                                           : q2e_pkg::TAB_LEN;
    // pre: products, sums, pole/sqrt prep (3); radicand 1; sqrt 32; atan2 NS+1; out 1
    localparam int SQ = 32;
    localparam int LAT = 3 + 1 + SQ + NS + 1 + 1;

    logic [15:0] thr_reg;
    logic [LAT-1:0] vld_reg;

    assign busy = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= 16'd32735;
            vld_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                thr_reg <= cfg_data;
            end
            vld_reg <= {vld_reg[LAT-2:0], start};
        end
    end

    // Stage 1: products.
    logic signed [31:0] xx_reg, yy_reg, zz_reg, ww_reg, xw_reg, yz_reg;
    logic signed [31:0] wy_reg, zx_reg, wz_reg, xy_reg;
    logic signed [15:0] qx_reg, qy_reg;
    always_ff @(posedge clk)
    begin
        xx_reg <= quat_x * quat_x;
        yy_reg <= quat_y * quat_y;
        zz_reg <= quat_z * quat_z;
        ww_reg <= quat_w * quat_w;
        xw_reg <= quat_x * quat_w;
        yz_reg <= quat_y * quat_z;
        wy_reg <= quat_w * quat_y;
        zx_reg <= quat_z * quat_x;
        wz_reg <= quat_w * quat_z;
        xy_reg <= quat_x * quat_y;
        qx_reg <= quat_x;
        qy_reg <= quat_y;
    end

    // Stage 2: norm, pole test value, atan2 operands.
    logic signed [34:0] n_reg, t_reg;
    logic signed [AW-1:0] y1_reg, x1_reg, y2_reg, x2_reg;
    logic signed [15:0] qx2_reg, qy2_reg;
    always_ff @(posedge clk)
    begin
        n_reg <= 35'(xx_reg) + 35'(yy_reg) + 35'(zz_reg) + 35'(ww_reg);
        t_reg <= 35'(xw_reg) - 35'(yz_reg);
        y1_reg <= AW'((35'(wy_reg) + 35'(zx_reg)) <<< 1);
        x1_reg <= AW'(35'(xx_reg) + 35'(yy_reg) + 35'(zz_reg) + 35'(ww_reg)
                  - ((35'(xx_reg) + 35'(yy_reg)) <<< 1));
        y2_reg <= AW'((35'(wz_reg) + 35'(xy_reg)) <<< 1);
        x2_reg <= AW'(35'(xx_reg) + 35'(yy_reg) + 35'(zz_reg) + 35'(ww_reg)
                  - ((35'(zz_reg) + 35'(xx_reg)) <<< 1));
        qx2_reg <= qx_reg;
        qy2_reg <= qy_reg;
    end

    // Stage 3: pole decision and radicand factors.
    logic [1:0] pole3_reg;
    logic zero3_reg;
    logic signed [AW-1:0] num3_reg;
    logic [31:0] p3_reg, q3_reg;
    logic signed [52:0] lim;
    logic signed [52:0] st;
    logic signed [36:0] pp, qq, nm;
    always_comb
    begin
        lim = 53'($signed({1'b0, thr_reg})) * 53'(n_reg);
        st = 53'(t_reg) <<< 16;
        pp = 37'(n_reg) - (37'(t_reg) <<< 1);
        qq = 37'(n_reg) + (37'(t_reg) <<< 1);
        nm = 37'(t_reg) <<< 1;
        if (pp < 0) pp = '0;
        if (qq < 0) qq = '0;
        if (n_reg >= 35'sd2147483648)
        begin
            pp = pp >>> 1;
            qq = qq >>> 1;
            nm = nm >>> 1;
        end
    end
    logic signed [AW-1:0] py3_reg, px3_reg;
    always_ff @(posedge clk)
    begin
        zero3_reg <= (n_reg == '0);
        pole3_reg <= (st > lim) ? q2e_pkg::POLE_NORTH
                   : (st < -lim) ? q2e_pkg::POLE_SOUTH : q2e_pkg::POLE_NONE;
        num3_reg <= AW'(nm);
        p3_reg <= 32'(pp);
        q3_reg <= 32'(qq);
        py3_reg <= AW'(qy2_reg);
        px3_reg <= AW'(qx2_reg);
    end

    // Square-root chain; radicand product taken at its head.
    logic [63:0] rad_reg;
    logic [63:0] srem [0:SQ];
    logic [31:0] sroot [0:SQ];
    always_ff @(posedge clk)
    begin
        rad_reg <= {32'd0, p3_reg} * {32'd0, q3_reg};
    end
    assign srem[0] = rad_reg;
    assign sroot[0] = '0;
    for (genvar b = 0; b < SQ; b++)
    begin : g_sq
        q2e_sqrt_cell #(.BIT(SQ - 1 - b)) u_sq (
            .clk(clk), .rem_in(srem[b]), .root_in(sroot[b]),
            .rem_out(srem[b+1]), .root_out(sroot[b+1]));
    end

    // Delay other operands alongside the sqrt chain.
    localparam int DL = SQ + 1;
    logic signed [AW-1:0] d_num [0:DL-1];
    logic signed [AW-1:0] d_y1 [0:DL-1];
    logic signed [AW-1:0] d_x1 [0:DL-1];
    logic signed [AW-1:0] d_y2 [0:DL-1];
    logic signed [AW-1:0] d_x2 [0:DL-1];
    logic signed [AW-1:0] d_py [0:DL-1];
    logic signed [AW-1:0] d_px [0:DL-1];
    logic [1:0] d_pole [0:DL-1];
    logic d_zero [0:DL-1];
    logic signed [AW-1:0] y1_3_reg, x1_3_reg, y2_3_reg, x2_3_reg;
    always_ff @(posedge clk)
    begin
        y1_3_reg <= y1_reg;
        x1_3_reg <= x1_reg;
        y2_3_reg <= y2_reg;
        x2_3_reg <= x2_reg;
        d_num[0] <= num3_reg;
        d_y1[0] <= y1_3_reg;
        d_x1[0] <= x1_3_reg;
        d_y2[0] <= y2_3_reg;
        d_x2[0] <= x2_3_reg;
        d_py[0] <= py3_reg;
        d_px[0] <= px3_reg;
        d_pole[0] <= pole3_reg;
        d_zero[0] <= zero3_reg;
        for (int k = 1; k < DL; k++)
        begin
            d_num[k] <= d_num[k-1];
            d_y1[k] <= d_y1[k-1];
            d_x1[k] <= d_x1[k-1];
            d_y2[k] <= d_y2[k-1];
            d_x2[k] <= d_x2[k-1];
            d_py[k] <= d_py[k-1];
            d_px[k] <= d_px[k-1];
            d_pole[k] <= d_pole[k-1];
            d_zero[k] <= d_zero[k-1];
        end
    end

    // Unit 0 serves asin or the pole atan2(y,x).
    logic signed [AW-1:0] a0y, a0x;
    always_comb
    begin
        if (d_pole[DL-1] != q2e_pkg::POLE_NONE)
        begin
            a0y = d_py[DL-1];
            a0x = d_px[DL-1];
        end
        else
        begin
            a0y = d_num[DL-1];
            a0x = AW'(sroot[SQ]);
        end
    end

    logic signed [q2e_pkg::ACC_W-1:0] ang0, ang1, ang2;
    q2e_atan2 #(.STAGES(CORDIC_STAGES)) u_a0 (.clk(clk), .yv(a0y), .xv(a0x), .angle(ang0));
    q2e_atan2 #(.STAGES(CORDIC_STAGES)) u_a1 (.clk(clk), .yv(d_y1[DL-1]),
                                              .xv(d_x1[DL-1]), .angle(ang1));
    q2e_atan2 #(.STAGES(CORDIC_STAGES)) u_a2 (.clk(clk), .yv(d_y2[DL-1]),
                                              .xv(d_x2[DL-1]), .angle(ang2));

    // Hold pole and zero flags across the atan2 chain.
    logic [1:0] e_pole [0:NS];
    logic e_zero [0:NS];
    always_ff @(posedge clk)
    begin
        e_pole[0] <= d_pole[DL-1];
        e_zero[0] <= d_zero[DL-1];
        for (int k = 1; k <= NS; k++)
        begin
            e_pole[k] <= e_pole[k-1];
            e_zero[k] <= e_zero[k-1];
        end
    end

    function automatic logic [15:0] to_q96(input logic signed [q2e_pkg::ACC_W:0] a);
        logic [q2e_pkg::ACC_W:0] mag;
        logic [18:0] r;
        logic [15:0] m;
        mag = a[q2e_pkg::ACC_W] ? -a : a;
        r = 19'((mag + 512) >> 10);
        // r < 4*23040: reduce by at most three compares
        if (r >= 19'd69120) r = r - 19'd69120;
        else if (r >= 19'd46080) r = r - 19'd46080;
        else if (r >= 19'd23040) r = r - 19'd23040;
        m = 16'(r);
        return a[q2e_pkg::ACC_W] ? -m : m;
    endfunction

    logic [15:0] ox_reg, oy_reg, oz_reg;
    logic [1:0] op_reg;
    logic signed [q2e_pkg::ACC_W:0] dbl;
    always_comb
    begin
        dbl = (q2e_pkg::ACC_W+1)'(ang0) <<< 1;
        if (e_pole[NS] == q2e_pkg::POLE_SOUTH) dbl = -dbl;
    end
    always_ff @(posedge clk)
    begin
        if (e_zero[NS])
        begin
            ox_reg <= '0; oy_reg <= '0; oz_reg <= '0; op_reg <= q2e_pkg::POLE_NONE;
        end
        else if (e_pole[NS] == q2e_pkg::POLE_NORTH || e_pole[NS] == q2e_pkg::POLE_SOUTH)
        begin
            ox_reg <= (e_pole[NS] == q2e_pkg::POLE_NORTH) ? q2e_pkg::RIGHT_ANGLE_Q96
                                                          : -q2e_pkg::RIGHT_ANGLE_Q96;
            oy_reg <= to_q96(dbl);
            oz_reg <= '0;
            op_reg <= e_pole[NS];
        end
        else
        begin
            ox_reg <= to_q96((q2e_pkg::ACC_W+1)'(ang0));
            oy_reg <= to_q96((q2e_pkg::ACC_W+1)'(ang1));
            oz_reg <= to_q96((q2e_pkg::ACC_W+1)'(ang2));
            op_reg <= q2e_pkg::POLE_NONE;
        end
    end

    assign done = vld_reg[LAT-1];
    assign angle_x_deg = ox_reg;
    assign angle_y_deg = oy_reg;
    assign angle_z_deg = oz_reg;
    assign pole_case = op_reg;
endmodule

>>> rtl/core/q2e_cell.sv
`timescale 1ns / 1ps
// One vectoring CORDIC micro-rotation, registered.
module q2e_cell #(
    parameter int STAGE = 0
) (
    input  logic              clk,
    input  q2e_pkg::cordic_t  din,
    output q2e_pkg::cordic_t  dout
);
    q2e_pkg::cordic_t dout_reg;
    q2e_pkg::cordic_t dout_next;
    logic signed [q2e_pkg::AW-1:0] dx;
    logic signed [q2e_pkg::AW-1:0] dy;

    always_comb
    begin
        dx = din.yv >>> STAGE;
        dy = din.xv >>> STAGE;
        dout_next = din;
        if (!din.yv[q2e_pkg::AW-1] && din.yv != '0)
        begin
            dout_next.xv  = din.xv + dx;
            dout_next.yv  = din.yv - dy;
            dout_next.acc = din.acc + q2e_pkg::atan_entry(STAGE);
        end
        else if (din.yv[q2e_pkg::AW-1])
        begin
            dout_next.xv  = din.xv - dx;
            dout_next.yv  = din.yv + dy;
            dout_next.acc = din.acc - q2e_pkg::atan_entry(STAGE);
        end
    end

    always_ff @(posedge clk)
    begin
        dout_reg <= dout_next;
    end

    assign dout = dout_reg;
endmodule

>>> rtl/core/q2e_sqrt_cell.sv
`timescale 1ns / 1ps
// One bit of a restoring square root, registered; rem carries radicand minus root squared.
module q2e_sqrt_cell #(
    parameter int BIT = 0
) (
    input  logic        clk,
    input  logic [63:0] rem_in,
    input  logic [31:0] root_in,
    output logic [63:0] rem_out,
    output logic [31:0] root_out
);
    logic [63:0] rem_reg;
    logic [31:0] root_reg;
    logic [63:0] rem_next;
    logic [31:0] root_next;
    logic [63:0] inc;

    always_comb
    begin
        // (root + 2^BIT)^2 - root^2 = root * 2^(BIT+1) + 2^(2*BIT)
        inc = ({32'd0, root_in} << (BIT + 1)) + (64'd1 << (2 * BIT));
        rem_next = rem_in;
        root_next = root_in;
        if (inc <= rem_in)
        begin
            rem_next = rem_in - inc;
            root_next = root_in | (32'd1 << BIT);
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign rem_out = rem_reg;
    assign root_out = root_reg;
endmodule

>>> rtl/core/q2e_atan2.sv
`timescale 1ns / 1ps
// atan2 pipeline: quadrant fold and normalization, then a chain of cells.
module q2e_atan2 #(
    parameter int STAGES = 16
) (
    input  logic                              clk,
    input  logic signed [q2e_pkg::AW-1:0]     yv,
    input  logic signed [q2e_pkg::AW-1:0]     xv,
    output logic signed [q2e_pkg::ACC_W-1:0]  angle
);
    localparam int NS = (STAGES < q2e_pkg::TAB_LEN) ? STAGES : q2e_pkg::TAB_LEN;
    q2e_pkg::cordic_t chain [0:NS];
    q2e_pkg::cordic_t fold_reg;
    q2e_pkg::cordic_t fold_next;
    logic signed [q2e_pkg::AW-1:0] fx;
    logic signed [q2e_pkg::AW-1:0] fy;
    logic [q2e_pkg::AW-1:0] mag;
    logic [q2e_pkg::AW-1:0] ay;
    logic [5:0] sh;

    always_comb
    begin
        fx = xv;
        fy = yv;
        fold_next.acc = '0;
        if (xv[q2e_pkg::AW-1])
        begin
            fold_next.acc = yv[q2e_pkg::AW-1] ? -q2e_pkg::HALF_TURN : q2e_pkg::HALF_TURN;
            fx = -xv;
            fy = -yv;
        end
        ay = fy[q2e_pkg::AW-1] ? -fy : fy;
        mag = (fx > $signed(ay)) ? fx : ay;
        sh = '0;
        for (int b = 39; b >= 0; b--)
        begin
            if (mag[b] && sh == 6'd0 && (mag >> (b + 1)) == '0)
            begin
                sh = 6'(39 - b);
            end
        end
        fold_next.xv = fx <<< sh;
        fold_next.yv = fy <<< sh;
        if (xv == '0 && yv == '0)
        begin
            fold_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        fold_reg <= fold_next;
    end

    assign chain[0] = fold_reg;
    for (genvar i = 0; i < NS; i++)
    begin : g_cell
        q2e_cell #(.STAGE(i)) u_cell (.clk(clk), .din(chain[i]), .dout(chain[i+1]));
    end

    assign angle = chain[NS].acc;
endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// Transaction-level check of quaternion_to_euler_angles: quaternions go in on the
// start/busy handshake, angles come back on the done strobe and are compared
// with a predictor kept in this file.
module tb_top;

    localparam int STAGES = 16;
    localparam int LATENCY = 3 + 32 + 2 + STAGES + 2;
    localparam logic [15:0] THRESH_RESET = 16'd32735;
    localparam logic [15:0] THRESH_MAX = 16'd32768;

    typedef struct packed {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic [1:0]         pole;
    } euler_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [15:0] quat_x, quat_y, quat_z, quat_w;
    logic cfg_valid;
    logic cfg_ready;
    logic [15:0] cfg_data;
    logic done;
    logic signed [15:0] angle_x_deg, angle_y_deg, angle_z_deg;
    logic [1:0] pole_case;

    // predictor copy of the threshold register
    logic [15:0] pred_thresh;
    euler_t angles_pending[$];
    int errors;
    int sent;
    int checked;
    int north_seen;
    int south_seen;
    int idle_pct;

    quaternion_to_euler_angles #(.CORDIC_STAGES(STAGES)) u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .done(done), .angle_x_deg(angle_x_deg), .angle_y_deg(angle_y_deg),
        .angle_z_deg(angle_z_deg), .pole_case(pole_case)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #50ms;
        $display("FAILURE");
        $finish;
    end

    // floor shift right of a signed value
    function automatic longint asr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint isqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return longint'(res);
    endfunction

    // vectoring atan2, result in 2^-16 degree units
    function automatic longint atan2_units(longint yv, longint xv);
        longint acc;
        longint mag;
        longint dx;
        longint dy;
        acc = 0;
        if (xv == 0 && yv == 0) return 0;
        if (xv < 0)
        begin
            acc = (yv >= 0) ? longint'(q2e_pkg::HALF_TURN) : -longint'(q2e_pkg::HALF_TURN);
            xv = -xv;
            yv = -yv;
        end
        mag = (yv < 0) ? -yv : yv;
        if (xv > mag) mag = xv;
        while (mag < (64'sd1 <<< 39))
        begin
            mag *= 2;
            xv *= 2;
            yv *= 2;
        end
        for (int i = 0; i < STAGES && i < q2e_pkg::TAB_LEN; i++)
        begin
            dx = asr_floor(yv, i);
            dy = asr_floor(xv, i);
            if (yv > 0)
            begin
                xv += dx;
                yv -= dy;
                acc += longint'(q2e_pkg::atan_entry(i));
            end
            else if (yv < 0)
            begin
                xv -= dx;
                yv += dy;
                acc -= longint'(q2e_pkg::atan_entry(i));
            end
        end
        return acc;
    endfunction

    // round to Q9.6, keep sign, wrap magnitude by a full turn
    function automatic logic [15:0] units_to_deg(longint a);
        longint unsigned mag;
        longint unsigned r;
        mag = (a < 0) ? longint'(-a) : longint'(a);
        r = ((mag + 512) >> 10) % longint'(q2e_pkg::FULL_TURN_Q96);
        if (a < 0) r = -r;
        return r[15:0];
    endfunction

    function automatic euler_t predict_euler(logic signed [15:0] qx, logic signed [15:0] qy,
                                             logic signed [15:0] qz, logic signed [15:0] qw);
        longint x, y, z, w, n, t, lim, st, p, q, num, root;
        euler_t e;
        x = qx; y = qy; z = qz; w = qw;
        n = x * x + y * y + z * z + w * w;
        t = x * w - y * z;
        lim = longint'(pred_thresh) * n;
        st = t * 65536;
        e = '0;
        if (n == 0) return e;
        if (st > lim)
        begin
            e.ax = q2e_pkg::RIGHT_ANGLE_Q96;
            e.ay = units_to_deg(2 * atan2_units(y, x));
            e.pole = q2e_pkg::POLE_NORTH;
        end
        else if (st < -lim)
        begin
            e.ax = -q2e_pkg::RIGHT_ANGLE_Q96;
            e.ay = units_to_deg(-2 * atan2_units(y, x));
            e.pole = q2e_pkg::POLE_SOUTH;
        end
        else
        begin
            p = n - 2 * t;
            q = n + 2 * t;
            num = 2 * t;
            if (p < 0) p = 0;
            if (q < 0) q = 0;
            if (n >= (64'sd1 <<< 31))
            begin
                p = asr_floor(p, 1);
                q = asr_floor(q, 1);
                num = asr_floor(num, 1);
            end
            root = isqrt(longint'(p) * longint'(q));
            e.ax = units_to_deg(atan2_units(num, root));
            e.ay = units_to_deg(atan2_units(2 * (w * y + z * x), n - 2 * (x * x + y * y)));
            e.az = units_to_deg(atan2_units(2 * (w * z + x * y), n - 2 * (z * z + x * x)));
            e.pole = q2e_pkg::POLE_NONE;
        end
        return e;
    endfunction

    // Compare each strobed result with the oldest expectation.
    always @(posedge clk)
    begin
        euler_t exp_e;
        if (rst_n && done)
        begin
            if (angles_pending.size() == 0)
            begin
                $error("result with no expectation pending");
                errors++;
            end
            else
            begin
                exp_e = angles_pending.pop_front();
                checked++;
                if (pole_case != exp_e.pole)
                begin
                    $error("pole_case exp %0d got %0d", exp_e.pole, pole_case);
                    errors++;
                end
                if (angle_x_deg != exp_e.ax)
                begin
                    $error("angle_x_deg exp %0d got %0d", exp_e.ax, angle_x_deg);
                    errors++;
                end
                if (angle_y_deg != exp_e.ay)
                begin
                    $error("angle_y_deg exp %0d got %0d", exp_e.ay, angle_y_deg);
                    errors++;
                end
                if (angle_z_deg != exp_e.az)
                begin
                    $error("angle_z_deg exp %0d got %0d", exp_e.az, angle_z_deg);
                    errors++;
                end
            end
        end
    end

    // Send one quaternion; hold start across back-to-back transactions.
    task automatic send_quat(logic signed [15:0] qx, logic signed [15:0] qy,
                             logic signed [15:0] qz, logic signed [15:0] qw);
        euler_t e;
        while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        quat_x <= qx;
        quat_y <= qy;
        quat_z <= qz;
        quat_w <= qw;
        @(posedge clk);
        while (busy) @(posedge clk);
        e = predict_euler(qx, qy, qz, qw);
        if (e.pole == q2e_pkg::POLE_NORTH) north_seen++;
        if (e.pole == q2e_pkg::POLE_SOUTH) south_seen++;
        angles_pending.push_back(e);
        sent++;
    endtask

    // Drop start, drain the pipeline, then hold idle for its full latency.
    task automatic drain;
        start <= 1'b0;
        while (angles_pending.size() != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // Write the threshold register while the block is idle.
    task automatic write_thresh(logic [15:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        pred_thresh = v;
        @(posedge clk);
    endtask

    task automatic test_directed;
        send_quat(0, 0, 0, 0);
        send_quat(16'sh7fff, 0, 0, 0);
        send_quat(-16'sh8000, 0, 0, 0);
        send_quat(0, 16'sh7fff, 0, 0);
        send_quat(0, -16'sh8000, 0, 0);
        send_quat(0, 0, 16'sh7fff, 0);
        send_quat(0, 0, -16'sh8000, 0);
        send_quat(0, 0, 0, 16'sh7fff);
        send_quat(0, 0, 0, -16'sh8000);
        // north pole, near-pole cases, full-scale and small quaternions
        send_quat(16'sd1000, 16'sd0, 16'sd0, 16'sd1000);
        send_quat(16'sd1000, 16'sd300, 16'sd0, 16'sd1000);
        send_quat(-16'sd1000, 16'sd200, 16'sd0, 16'sd1000);
        send_quat(-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000);
        send_quat(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_quat(-16'sh8000, 16'sh7fff, -16'sh8000, 16'sh7fff);
        send_quat(16'sd1, 16'sd0, 16'sd0, 16'sd0);
        send_quat(16'sd0, 16'sd0, 16'sd1, 16'sd1);
        send_quat(16'sd3, -16'sd5, 16'sd7, -16'sd2);
    endtask

    // Random mix: full range, near-pole (x~w or x~-w), small magnitudes.
    task automatic test_random(int count);
        logic signed [15:0] a, b, c, d;
        for (int k = 0; k < count; k++)
        begin
            a = $urandom; b = $urandom; c = $urandom; d = $urandom;
            case ($urandom_range(3, 0))
                0: ;
                1:
                begin
                    d = a + $signed(16'($urandom_range(64, 0))) - 16'sd32;
                    c = c >>> $urandom_range(12, 4);
                end
                2:
                begin
                    d = -a + $signed(16'($urandom_range(64, 0))) - 16'sd32;
                    b = b >>> $urandom_range(12, 4);
                end
                default:
                begin
                    a = a >>> $urandom_range(15, 8);
                    b = b >>> $urandom_range(15, 8);
                    c = c >>> $urandom_range(15, 8);
                    d = d >>> $urandom_range(15, 8);
                end
            endcase
            send_quat(a, b, c, d);
        end
    endtask

    task automatic test_thresholds;
        write_thresh(16'd0);
        test_random(60);
        write_thresh(THRESH_MAX);
        test_random(60);
        write_thresh(16'hffff);
        test_random(30);
        write_thresh(16'($urandom_range(32768, 16000)));
        test_random(60);
        write_thresh(THRESH_RESET);
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        quat_x = '0; quat_y = '0; quat_z = '0; quat_w = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        pred_thresh = THRESH_RESET;
        errors = 0; sent = 0; checked = 0;
        north_seen = 0; south_seen = 0;
        idle_pct = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        idle_pct = 37;
        test_random(180);
        test_thresholds();
        idle_pct = 54;
        test_random(160);
        idle_pct = 0;
        test_random(160);
        drain();

        $display("Checked %0d of %0d quaternions (%0d north, %0d south pole)",
                 checked, sent, north_seen, south_seen);
        $display("Thresholds covered: 0, 32768, 65535, random, reset default");
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
